// ===== rtl/owss_pkg.sv =====
// ----------------------------------------------------------------------------
// owss_pkg
// Shared types and constants for the one-wire slave time-slot decoder.
// ----------------------------------------------------------------------------
package owss_pkg;

    // Width of every timing register.
    localparam int CFG_W          = 10;
    localparam int COUNT_BITS_DEF = 10;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_ENABLE      = 3'd0;
    localparam logic [2:0] REG_ONE_DELAY   = 3'd1;
    localparam logic [2:0] REG_ZERO_EXTRA  = 3'd2;
    localparam logic [2:0] REG_RESET_EXTRA = 3'd3;
    localparam logic [2:0] REG_DRIVE_TIME  = 3'd4;

    // Reset values of the timing registers.
    localparam logic [CFG_W-1:0] ONE_DELAY_RST   = 10'd15;
    localparam logic [CFG_W-1:0] ZERO_EXTRA_RST  = 10'd45;
    localparam logic [CFG_W-1:0] RESET_EXTRA_RST = 10'd420;
    localparam logic [CFG_W-1:0] DRIVE_TIME_RST  = 10'd45;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ONE   = 2'd1,
        EV_ZERO  = 2'd2,
        EV_RESET = 2'd3
    } ev_t;

    typedef struct packed {
        logic             enable;
        logic [CFG_W-1:0] one_sample_delay;
        logic [CFG_W-1:0] zero_extra_delay;
        logic [CFG_W-1:0] reset_extra_delay;
        logic [CFG_W-1:0] drive_low_time;
    } cfg_t;

endpackage

// ===== rtl/owss_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// owss_cfg_regs
// APB register file holding the enable bit and the four timing values.
// ----------------------------------------------------------------------------
module owss_cfg_regs import owss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable            <= 1'b0;
            cfg_reg.one_sample_delay  <= ONE_DELAY_RST;
            cfg_reg.zero_extra_delay  <= ZERO_EXTRA_RST;
            cfg_reg.reset_extra_delay <= RESET_EXTRA_RST;
            cfg_reg.drive_low_time    <= DRIVE_TIME_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ENABLE:      cfg_reg.enable            <= pwdata[0];
                REG_ONE_DELAY:   cfg_reg.one_sample_delay  <= pwdata[CFG_W-1:0];
                REG_ZERO_EXTRA:  cfg_reg.zero_extra_delay  <= pwdata[CFG_W-1:0];
                REG_RESET_EXTRA: cfg_reg.reset_extra_delay <= pwdata[CFG_W-1:0];
                REG_DRIVE_TIME:  cfg_reg.drive_low_time    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_ENABLE:      prdata = APB_DW'(cfg_reg.enable);
            REG_ONE_DELAY:   prdata = APB_DW'(cfg_reg.one_sample_delay);
            REG_ZERO_EXTRA:  prdata = APB_DW'(cfg_reg.zero_extra_delay);
            REG_RESET_EXTRA: prdata = APB_DW'(cfg_reg.reset_extra_delay);
            REG_DRIVE_TIME:  prdata = APB_DW'(cfg_reg.drive_low_time);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== rtl/owss_slot_fsm.sv =====
// ----------------------------------------------------------------------------
// owss_slot_fsm
// Slot state machine: edge detector, saturating tick counter and the
// three-sample decision. Advances once per accepted line sample.
// ----------------------------------------------------------------------------
module owss_slot_fsm import owss_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic step,
    input  logic line_level,
    input  logic reply_bit,
    input  cfg_t cfg,
    output logic drive_low,
    output ev_t  event_res
);

    localparam int CmpW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_WAIT1 = 5'b00010,
        PH_WAIT2 = 5'b00100,
        PH_WAIT3 = 5'b01000,
        PH_DRIVE = 5'b10000
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic                    prev_level_reg;
    logic [COUNT_BITS-1:0]   tick_count_reg, tick_count_next;
    logic [COUNT_BITS-1:0]   tick_inc;
    logic [CFG_W-1:0]        limit;
    logic                    reached;

    // A zero setting counts as one tick; settings above the counter range
    // clamp to the counter maximum.
    function automatic logic [CmpW-1:0] target_of(input logic [CFG_W-1:0] v);
        logic [CmpW-1:0] t;
        t = CmpW'(v);
        if (v == '0) t = CmpW'(1);
        if (t > CmpW'(CountMax)) t = CmpW'(CountMax);
        return t;
    endfunction

    assign tick_inc = (tick_count_reg == CountMax) ? tick_count_reg
                                                   : tick_count_reg + 1'b1;

    always_comb begin
        case (phase_reg)
            PH_WAIT1: limit = cfg.one_sample_delay;
            PH_WAIT2: limit = cfg.zero_extra_delay;
            PH_WAIT3: limit = cfg.reset_extra_delay;
            default:  limit = cfg.drive_low_time;
        endcase
    end

    assign reached = CmpW'(tick_inc) >= target_of(limit);

    always_comb begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        drive_low       = 1'b0;
        event_res       = EV_NONE;
        case (phase_reg)
            PH_WAIT1: begin
                tick_count_next = tick_inc;
                if (reached) begin
                    tick_count_next = '0;
                    if (line_level) begin
                        event_res  = EV_ONE;
                        phase_next = reply_bit ? PH_IDLE : PH_DRIVE;
                    end else begin
                        phase_next = PH_WAIT2;
                    end
                end
            end
            PH_WAIT2: begin
                tick_count_next = tick_inc;
                if (reached) begin
                    tick_count_next = '0;
                    if (line_level) begin
                        event_res  = EV_ZERO;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_WAIT3;
                    end
                end
            end
            PH_WAIT3: begin
                tick_count_next = tick_inc;
                if (reached) begin
                    tick_count_next = '0;
                    if (line_level) begin
                        event_res  = EV_RESET;
                        phase_next = PH_DRIVE;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_DRIVE: begin
                drive_low       = 1'b1;
                tick_count_next = tick_inc;
                if (reached) begin
                    tick_count_next = '0;
                    phase_next      = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (cfg.enable && prev_level_reg && !line_level) begin
                    tick_count_next = '0;
                    phase_next      = PH_WAIT1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            prev_level_reg <= 1'b1;
            tick_count_reg <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            prev_level_reg <= line_level;
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

// ===== rtl/one_wire_slave_slot_decoder.sv =====
// ----------------------------------------------------------------------------
// one_wire_slave_slot_decoder
// One-wire bus slave time-slot decoder with a stream input of line samples
// and a stream output of drive and event results.
// ----------------------------------------------------------------------------
// Each input item is one line sample per microsecond tick and yields exactly
// one result item: whether the slave pulls the line low on that tick and
// which slot event, if any, was decided there. The block takes one item per
// clock cycle unless the output stalls; the result is written to the output
// register when the item is accepted, and the input stays ready while that
// register is empty or being drained. The slot state machine and tick counter
// advance only on accepted items, so stalls on either side do not disturb
// timing, which is counted in items. The user must write timing registers
// over the APB port only while the stream is idle; the block does not check.
module one_wire_slave_slot_decoder import owss_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // Line samples
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] line_level, [1] reply_bit
    // Results
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata    // [0] drive_low, [2:1] event_res
);

    cfg_t cfg;
    logic accept;
    logic drive_comb;
    ev_t  event_comb;
    logic m_valid_reg;
    logic drive_reg;
    ev_t  event_reg;

    owss_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    owss_slot_fsm #(
        .COUNT_BITS (COUNT_BITS)
    ) u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (accept),
        .line_level (s_tdata[0]),
        .reply_bit  (s_tdata[1]),
        .cfg        (cfg),
        .drive_low  (drive_comb),
        .event_res  (event_comb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_reg <= drive_comb;
            event_reg <= event_comb;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, event_reg, drive_reg};

    // Events are decided only on sample ticks, never while the slave drives.
    a_no_event_while_driving: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (event_reg != EV_NONE) |-> !drive_reg)
        else $error("event reported on a driven tick");

    // An empty output register never blocks the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    // Every accepted item produces a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted item produced no result");

endmodule
